### hdl/glyph_quad_layout_macros.svh
// Assertion macros for the glyph quad layout block.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef GLYPH_QUAD_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_LAYOUT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GQL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GQL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gql_pkg.sv
// Shared types, codes, constants and saturation helpers for glyph_quad_layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gql_pkg;

  localparam int MAX_CHARS_DEF   = 256;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam int CODE_W   = 8;
  localparam int GW_W     = 8;
  localparam int POS_W    = 16;
  localparam int PITCH_W  = 9;
  localparam int TEX_W    = 17;
  localparam int LH_W     = 12;
  localparam int VIDX_W   = 10;
  localparam int CORNER_W = 2;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int PROD_W   = 26;
  localparam int SUM_W    = 18;

  localparam logic [OP_W-1:0] OP_WIDTH_WR = 2'd0;
  localparam logic [OP_W-1:0] OP_START    = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAR     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CHAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd4;

  localparam logic [CODE_W-1:0]  BASE_CHAR_RST   = 8'd32;
  localparam logic [PITCH_W-1:0] ROW_PITCH_RST   = 9'd16;
  localparam logic [TEX_W-1:0]   COL_STEP_RST    = 17'd4096;
  localparam logic [TEX_W-1:0]   ROW_STEP_RST    = 17'd4096;
  localparam logic [LH_W-1:0]    LINE_HEIGHT_RST = 12'd16;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [TEX_W-1:0]  TEX_ONE      = 17'd65536;

  localparam logic [CORNER_W-1:0] CORNER_BL = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_BR = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_TR = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_TL = 2'd3;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [CODE_W-1:0] quot;
    logic [CODE_W-1:0] rem;
  } div_res_t;

  function automatic logic [POS_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [TEX_W-1:0] sattex(input logic [PROD_W-1:0] v);
    logic [TEX_W-1:0] r;
    if (v > PROD_W'(TEX_ONE)) begin
      r = TEX_ONE;
    end else begin
      r = v[TEX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/gql_cell_div.sv
// Bit-serial restoring divider that splits an atlas cell index into row and column.
// Depends on gql_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gql_cell_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [gql_pkg::CODE_W-1:0]  dividend,
  input  wire logic [gql_pkg::PITCH_W-1:0] divisor,
  output gql_pkg::div_res_t                res
);

  localparam int STEP_W = $clog2(gql_pkg::CODE_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [gql_pkg::CODE_W-1:0]  quo_r, quo_nxt;
  logic [gql_pkg::CODE_W-1:0]  rem_r, rem_nxt;
  logic [gql_pkg::PITCH_W-1:0] div_r, div_nxt;
  logic [gql_pkg::PITCH_W-1:0] trial;
  logic                        fits;

  assign trial = {rem_r, quo_r[gql_pkg::CODE_W-1]};
  assign fits  = (trial >= div_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[gql_pkg::CODE_W-2:0], fits};
      rem_nxt  = fits ? gql_pkg::CODE_W'(trial - div_r) : trial[gql_pkg::CODE_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(gql_pkg::CODE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

### hdl/glyph_quad_layout.sv
// Top level of the glyph quad layout block: width table memory, cursor state and vertex output.
// Depends on gql_pkg, gql_cell_div and glyph_quad_layout_macros.svh.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata, in_tuser
//   out_     master     out_tvalid/out_tready out_tdata, out_tuser, out_tlast
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Width writes, start beats, newlines and dropped characters are handled in ST_IDLE,
// which stays ready for the next beat. A drawn character goes through eight divider
// steps in ST_DIV until the divider reports done, a multiply in ST_MUL and four beats
// in ST_EMIT; the next beat is taken only after the block is back in ST_IDLE.
// Reset is synchronous and active low; the width table is not cleared.
// Output stalls hold the vertex sequencer; the last vertex waits in the output register
// while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_quad_layout_macros.svh"

module glyph_quad_layout #(
  parameter int MAX_CHARS   = gql_pkg::MAX_CHARS_DEF,
  parameter int TABLE_DEPTH = gql_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // char_code[7:0], glyph_width[15:8], origin_x[31:16], origin_y[47:32]
  input  wire logic [47:0] in_tdata,
  // op[1:0]
  input  wire logic [1:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // pos_x[15:0], pos_y[31:16], tex_u[48:32], tex_v[65:49], vertex_index[75:66], zeros above
  output      logic [79:0] out_tdata,
  // corner[1:0]
  output      logic [1:0]  out_tuser,
  output      logic        out_tlast,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int POS_W  = gql_pkg::POS_W;
  localparam int TEX_W  = gql_pkg::TEX_W;
  localparam int SUM_W  = gql_pkg::SUM_W;
  localparam int PROD_W = gql_pkg::PROD_W;
  localparam int CODE_W = gql_pkg::CODE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [CODE_W-1:0]           base_char_r;
  logic [gql_pkg::PITCH_W-1:0] row_pitch_r;
  logic [TEX_W-1:0]            col_step_r;
  logic [TEX_W-1:0]            row_step_r;
  logic [gql_pkg::LH_W-1:0]    line_height_r;

  logic [1:0]                  state_r, state_nxt;
  logic [POS_W-1:0]            cursor_x_r, cursor_x_nxt;
  logic [POS_W-1:0]            cursor_y_r, cursor_y_nxt;
  logic [POS_W-1:0]            line_x_r, line_x_nxt;
  logic [CNT_W-1:0]            chars_r, chars_nxt;
  logic [gql_pkg::VIDX_W-1:0]  vcnt_r, vcnt_nxt;
  logic [gql_pkg::CORNER_W-1:0] corner_r, corner_nxt;

  logic [gql_pkg::GW_W-1:0]    width_mem [TABLE_DEPTH];
  logic [gql_pkg::GW_W-1:0]    wdat_r;
  logic                        wok_r;

  logic [POS_W-1:0]            x1_r, y1_r;
  logic [TEX_W-1:0]            u0_r, v0_r;

  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [POS_W-1:0]            out_x_r, out_y_r;
  logic [TEX_W-1:0]            out_u_r, out_v_r;
  logic [gql_pkg::VIDX_W-1:0]  out_vidx_r;
  logic [gql_pkg::CORNER_W-1:0] out_corner_r;

  logic [gql_pkg::OP_W-1:0]    in_op;
  logic [CODE_W-1:0]           in_code;
  logic [gql_pkg::GW_W-1:0]    in_gw;
  logic [POS_W-1:0]            in_ox;
  logic [POS_W-1:0]            in_oy;
  logic                        in_acc;
  logic                        code_in_tbl;
  logic                        under_limit;
  logic                        draw_char;
  logic [CODE_W-1:0]           atlas_idx;
  logic [gql_pkg::PITCH_W-1:0] pitch;
  gql_pkg::div_res_t           div_res;
  logic [PROD_W-1:0]           prod_u, prod_v;
  logic [gql_pkg::GW_W-1:0]    glyph_w;
  logic [TEX_W-1:0]            u1, v1;
  logic                        out_load;
  logic [POS_W-1:0]            sel_x, sel_y;
  logic [TEX_W-1:0]            sel_u, sel_v;

  assign in_op   = in_tuser;
  assign in_code = in_tdata[7:0];
  assign in_gw   = in_tdata[15:8];
  assign in_ox   = in_tdata[31:16];
  assign in_oy   = in_tdata[47:32];

  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign code_in_tbl = ({1'b0, in_code} < (CODE_W + 1)'(TABLE_DEPTH));
  assign under_limit = (chars_r < CNT_W'(MAX_CHARS));
  assign draw_char   = (in_op == gql_pkg::OP_CHAR) && under_limit &&
                       (in_code != gql_pkg::NEWLINE_CODE);
  assign atlas_idx   = in_code - base_char_r;
  assign pitch       = (row_pitch_r == '0) ? gql_pkg::PITCH_W'(1) : row_pitch_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_char_r   <= gql_pkg::BASE_CHAR_RST;
      row_pitch_r   <= gql_pkg::ROW_PITCH_RST;
      col_step_r    <= gql_pkg::COL_STEP_RST;
      row_step_r    <= gql_pkg::ROW_STEP_RST;
      line_height_r <= gql_pkg::LINE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gql_pkg::CFG_BASE_CHAR:   base_char_r   <= cfg_data[CODE_W-1:0];
        gql_pkg::CFG_ROW_PITCH:   row_pitch_r   <= cfg_data[gql_pkg::PITCH_W-1:0];
        gql_pkg::CFG_COL_STEP:    col_step_r    <= cfg_data[TEX_W-1:0];
        gql_pkg::CFG_ROW_STEP:    row_step_r    <= cfg_data[TEX_W-1:0];
        gql_pkg::CFG_LINE_HEIGHT: line_height_r <= cfg_data[gql_pkg::LH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_op == gql_pkg::OP_WIDTH_WR) && code_in_tbl) begin
      width_mem[in_code[TBL_AW-1:0]] <= in_gw;
    end
    if (in_acc) begin
      wdat_r <= width_mem[in_code[TBL_AW-1:0]];
      wok_r  <= code_in_tbl;
    end
  end

  gql_cell_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && draw_char),
    .dividend (atlas_idx),
    .divisor  (pitch),
    .res      (div_res)
  );

  assign glyph_w = wok_r ? wdat_r : '0;
  assign prod_u  = PROD_W'(div_res.rem * col_step_r);
  assign prod_v  = PROD_W'(div_res.quot * row_step_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      u0_r <= gql_pkg::sattex(prod_u);
      v0_r <= gql_pkg::sattex(prod_v);
      x1_r <= gql_pkg::sat16(SUM_W'($signed(cursor_x_r)) + $signed({10'b0, glyph_w}));
      y1_r <= gql_pkg::sat16(SUM_W'($signed(cursor_y_r)) + $signed({6'b0, line_height_r}));
    end
  end

  assign u1 = gql_pkg::sattex(PROD_W'(u0_r) + PROD_W'(col_step_r));
  assign v1 = gql_pkg::sattex(PROD_W'(v0_r) + PROD_W'(row_step_r));

  always_comb begin
    case (corner_r)
      gql_pkg::CORNER_BL: begin
        sel_x = cursor_x_r; sel_y = cursor_y_r; sel_u = u0_r; sel_v = v1;
      end
      gql_pkg::CORNER_BR: begin
        sel_x = x1_r;       sel_y = cursor_y_r; sel_u = u1;   sel_v = v1;
      end
      gql_pkg::CORNER_TR: begin
        sel_x = x1_r;       sel_y = y1_r;       sel_u = u1;   sel_v = v0_r;
      end
      default: begin
        sel_x = cursor_x_r; sel_y = y1_r;       sel_u = u0_r; sel_v = v0_r;
      end
    endcase
  end

  assign out_load = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_x_nxt   = line_x_r;
    chars_nxt    = chars_r;
    vcnt_nxt     = vcnt_r;
    corner_nxt   = corner_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            gql_pkg::OP_START: begin
              cursor_x_nxt = in_ox;
              line_x_nxt   = in_ox;
              cursor_y_nxt = gql_pkg::sat16(SUM_W'($signed(in_oy)) -
                                            $signed({6'b0, line_height_r}));
              chars_nxt    = '0;
              vcnt_nxt     = '0;
            end
            gql_pkg::OP_CHAR: begin
              if (under_limit) begin
                chars_nxt = chars_r + 1'b1;
                if (in_code == gql_pkg::NEWLINE_CODE) begin
                  cursor_x_nxt = line_x_r;
                  cursor_y_nxt = gql_pkg::sat16(SUM_W'($signed(cursor_y_r)) -
                                                $signed({6'b0, line_height_r}));
                end else begin
                  state_nxt = ST_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt  = ST_EMIT;
        corner_nxt = gql_pkg::CORNER_BL;
      end
      ST_EMIT: begin
        if (out_load) begin
          corner_nxt = corner_r + 1'b1;
          if (corner_r == gql_pkg::CORNER_TL) begin
            state_nxt    = ST_IDLE;
            vcnt_nxt     = vcnt_r + gql_pkg::VIDX_W'(4);
            cursor_x_nxt = x1_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      line_x_r     <= '0;
      chars_r      <= '0;
      vcnt_r       <= '0;
      corner_r     <= gql_pkg::CORNER_BL;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      line_x_r     <= line_x_nxt;
      chars_r      <= chars_nxt;
      vcnt_r       <= vcnt_nxt;
      corner_r     <= corner_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r      <= sel_x;
      out_y_r      <= sel_y;
      out_u_r      <= sel_u;
      out_v_r      <= sel_v;
      out_vidx_r   <= vcnt_r + gql_pkg::VIDX_W'(corner_r);
      out_corner_r <= corner_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_vidx_r, out_v_r, out_u_r, out_y_r, out_x_r};
  assign out_tuser  = out_corner_r;
  assign out_tlast  = (out_corner_r == gql_pkg::CORNER_TL);

  `GQL_ASSERT_NEXT(a_char_enters_div, in_acc && draw_char, state_r == ST_DIV, "char not dividing")
  `GQL_ASSERT_SAME(a_div_done_in_div, div_res.done, state_r == ST_DIV, "divider done out of state")
  `GQL_ASSERT_SAME(a_ready_div_idle, in_tready, !div_res.busy, "ready while divider busy")
  `GQL_ASSERT_SAME(a_vidx_corner, out_tvalid_r, out_vidx_r[1:0] == out_corner_r, "vertex index skew")

endmodule

`default_nettype wire

### test/tb_glyph_quad_layout.sv
`timescale 1ns / 1ps
// Testbench for glyph_quad_layout: width writes, string starts and characters under
// random stalls, with every corner vertex predicted in the bench and compared per field.
// Depends on gql_pkg and the glyph_quad_layout RTL.

module tb_glyph_quad_layout;

  localparam logic [gql_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_DIRECTED = 24;
  localparam int N_SETTINGS = 6;
  localparam int PHASE_ITEMS = 4;
  localparam int IDLE_GAP = 24;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  code;
    logic [7:0]  gw;
    logic [15:0] ox;
    logic [15:0] oy;
  } glyph_item_t;

  typedef struct packed {
    int x0;
    int y0;
    int x1;
    int y1;
    int u0;
    int v0;
    int u1;
    int v1;
  } quad_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
    logic [7:0] gw;
    int         ox;
    int         oy;
    bit         typed;
    quad_t      q;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  base;
    logic [8:0]  pitch;
    logic [16:0] col_step;
    logic [16:0] row_step;
    logic [11:0] lh;
  } layout_cfg_t;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [16:0] tu;
    logic [16:0] tv;
    logic [9:0]  vidx;
    logic [1:0]  corner;
    logic        last;
  } vertex_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  logic [7:0]  adv_width [256];
  bit          adv_known [256];
  logic [7:0]  known_codes [$];
  int          cur_x;
  int          cur_y;
  int          line_x;
  int unsigned chars_in_str;
  logic [9:0]  vtx_next;
  layout_cfg_t cfg_now;
  vertex_t     pending_vertices [$];
  dir_row_t    directed_tbl [N_DIRECTED];

  int errors = 0;
  int n_items = 0;
  int n_vertices = 0;
  int n_dropped = 0;
  int n_cfg = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  glyph_quad_layout uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clamp_tex(input longint v);
    return (v > longint'(gql_pkg::TEX_ONE)) ? int'(gql_pkg::TEX_ONE) : int'(v);
  endfunction

  function automatic vertex_t corner_vertex(input quad_t q, input logic [1:0] c,
                                            input logic [9:0] first_idx);
    bit      right;
    bit      top;
    vertex_t vx;
    right = (c == gql_pkg::CORNER_BR) || (c == gql_pkg::CORNER_TR);
    top = (c == gql_pkg::CORNER_TR) || (c == gql_pkg::CORNER_TL);
    vx.px = right ? q.x1[15:0] : q.x0[15:0];
    vx.py = top ? q.y1[15:0] : q.y0[15:0];
    vx.tu = right ? q.u1[16:0] : q.u0[16:0];
    vx.tv = top ? q.v0[16:0] : q.v1[16:0];
    vx.vidx = first_idx + 10'(c);
    vx.corner = c;
    vx.last = (c == gql_pkg::CORNER_TL);
    return vx;
  endfunction

  task automatic advance_layout(input glyph_item_t it, input bit typed, input quad_t tq);
    int          lh;
    int unsigned pitch;
    int unsigned row_n;
    int unsigned col_n;
    logic [7:0]  cell_idx;
    quad_t       q;
    lh = int'(cfg_now.lh);
    n_items++;
    case (it.op)
      gql_pkg::OP_WIDTH_WR: begin
        adv_width[it.code] = it.gw;
        if (!adv_known[it.code]) begin
          adv_known[it.code] = 1'b1;
          known_codes.push_back(it.code);
        end
      end
      gql_pkg::OP_START: begin
        cur_x = int'($signed(it.ox));
        line_x = cur_x;
        cur_y = clamp16(int'($signed(it.oy)) - lh);
        chars_in_str = 0;
        vtx_next = '0;
      end
      gql_pkg::OP_CHAR: begin
        if (chars_in_str >= gql_pkg::MAX_CHARS_DEF) begin
          n_dropped++;
        end else if (it.code == gql_pkg::NEWLINE_CODE) begin
          chars_in_str++;
          cur_y = clamp16(cur_y - lh);
          cur_x = line_x;
        end else begin
          chars_in_str++;
          cell_idx = it.code - cfg_now.base;
          pitch = (cfg_now.pitch == 0) ? 1 : int'(cfg_now.pitch);
          row_n = cell_idx / pitch;
          col_n = cell_idx - row_n * pitch;
          q.x0 = cur_x;
          q.y0 = cur_y;
          q.x1 = clamp16(cur_x + int'(adv_width[it.code]));
          q.y1 = clamp16(cur_y + lh);
          q.u0 = clamp_tex(longint'(col_n) * longint'(cfg_now.col_step));
          q.v0 = clamp_tex(longint'(row_n) * longint'(cfg_now.row_step));
          q.u1 = clamp_tex(longint'(q.u0) + longint'(cfg_now.col_step));
          q.v1 = clamp_tex(longint'(q.v0) + longint'(cfg_now.row_step));
          if (typed) begin
            q = tq;
          end
          pending_vertices.push_back(corner_vertex(q, gql_pkg::CORNER_BL, vtx_next));
          pending_vertices.push_back(corner_vertex(q, gql_pkg::CORNER_BR, vtx_next));
          pending_vertices.push_back(corner_vertex(q, gql_pkg::CORNER_TR, vtx_next));
          pending_vertices.push_back(corner_vertex(q, gql_pkg::CORNER_TL, vtx_next));
          n_vertices += 4;
          vtx_next = vtx_next + 10'd4;
          cur_x = q.x1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_item(input glyph_item_t it, input bit typed, input quad_t tq);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {it.oy, it.ox, it.gw, it.code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_layout(it, typed, tq);
  endtask

  task automatic write_reg(input logic [gql_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gql_pkg::CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gql_pkg::CFG_BASE_CHAR:   cfg_now.base = val[7:0];
      gql_pkg::CFG_ROW_PITCH:   cfg_now.pitch = val[8:0];
      gql_pkg::CFG_COL_STEP:    cfg_now.col_step = val;
      gql_pkg::CFG_ROW_STEP:    cfg_now.row_step = val;
      gql_pkg::CFG_LINE_HEIGHT: cfg_now.lh = val[11:0];
      default: begin
      end
    endcase
    n_cfg++;
  endtask

  task automatic load_setting(input layout_cfg_t s);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    write_reg(gql_pkg::CFG_BASE_CHAR, 17'(s.base));
    write_reg(gql_pkg::CFG_ROW_PITCH, 17'(s.pitch));
    write_reg(gql_pkg::CFG_COL_STEP, s.col_step);
    write_reg(gql_pkg::CFG_ROW_STEP, s.row_step);
    write_reg(gql_pkg::CFG_LINE_HEIGHT, 17'(s.lh));
    cfg_valid <= 1'b0;
  endtask

  function automatic glyph_item_t random_item();
    glyph_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.code = 8'($urandom);
    it.gw = 8'($urandom);
    it.ox = 16'($urandom);
    it.oy = 16'($urandom);
    if (pick < 10) begin
      it.op = gql_pkg::OP_WIDTH_WR;
    end else if (pick < 16) begin
      it.op = gql_pkg::OP_START;
      if ($urandom_range(0, 3) == 0) it.ox = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      if ($urandom_range(0, 3) == 0) it.oy = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end else if (pick < 20) begin
      it.op = OP_UNUSED;
    end else if (pick < 32) begin
      it.op = gql_pkg::OP_CHAR;
      it.code = gql_pkg::NEWLINE_CODE;
    end else begin
      it.op = gql_pkg::OP_CHAR;
      it.code = known_codes[$urandom_range(0, known_codes.size() - 1)];
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  initial begin
    vertex_t want;
    int      rx_cycle;
    int      rx_mode;
    int      hold_left;
    rx_cycle = 0;
    rx_mode = 0;
    hold_left = HOLD_CYCLES;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_vertices.size() == 0) begin
          errors++;
          $display("%0t: vertex beat with none pending, expected nothing, actual tdata %h",
                   $time, out_tdata);
        end else begin
          want = pending_vertices.pop_front();
          check_field("pos_x", 17'(want.px), 17'(out_tdata[15:0]));
          check_field("pos_y", 17'(want.py), 17'(out_tdata[31:16]));
          check_field("tex_u", want.tu, out_tdata[48:32]);
          check_field("tex_v", want.tv, out_tdata[65:49]);
          check_field("vertex_index", 17'(want.vidx), 17'(out_tdata[75:66]));
          check_field("corner", 17'(want.corner), 17'(out_tuser));
          check_field("last", 17'(want.last), 17'(out_tlast));
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_req && hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (rx_cycle % 3) != 0;
          default: out_tready <= $urandom_range(0, 4) != 0;
        endcase
      end
    end
  end

  initial begin
    glyph_item_t it;
    dir_row_t    drow;
    layout_cfg_t settings [N_SETTINGS];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cur_x = 0;
    cur_y = 0;
    line_x = 0;
    chars_in_str = 0;
    vtx_next = '0;
    cfg_now = '{gql_pkg::BASE_CHAR_RST, gql_pkg::ROW_PITCH_RST, gql_pkg::COL_STEP_RST,
                gql_pkg::ROW_STEP_RST, gql_pkg::LINE_HEIGHT_RST};

    directed_tbl = '{
      '{gql_pkg::OP_WIDTH_WR, 8'd65, 8'd8, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_WIDTH_WR, 8'd0, 8'd255, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_WIDTH_WR, 8'd255, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_WIDTH_WR, 8'd32, 8'd5, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_START, 8'd0, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_CHAR, 8'd65, 8'd0, 0, 0, 1'b1,
        '{0, -16, 8, 0, 4096, 8192, 8192, 12288}},
      '{gql_pkg::OP_CHAR, 8'd32, 8'd0, 0, 0, 1'b1, '{8, -16, 13, 0, 0, 0, 4096, 4096}},
      '{gql_pkg::OP_CHAR, gql_pkg::NEWLINE_CODE, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_CHAR, 8'd0, 8'd0, 0, 0, 1'b1,
        '{0, -32, 255, -16, 0, 57344, 4096, 61440}},
      '{gql_pkg::OP_CHAR, 8'd255, 8'd0, 0, 0, 1'b1,
        '{255, -32, 255, -16, 61440, 53248, 65536, 57344}},
      '{OP_UNUSED, 8'd65, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_START, 8'd0, 8'd0, 32767, -32768, 1'b0, '0},
      '{gql_pkg::OP_CHAR, 8'd0, 8'd0, 0, 0, 1'b1,
        '{32767, -32768, 32767, -32752, 0, 57344, 4096, 61440}},
      '{gql_pkg::OP_CHAR, gql_pkg::NEWLINE_CODE, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_START, 8'd0, 8'd0, -32768, 32767, 1'b0, '0},
      '{gql_pkg::OP_CHAR, 8'd0, 8'd0, 0, 0, 1'b1,
        '{-32768, 32751, -32513, 32767, 0, 57344, 4096, 61440}},
      '{gql_pkg::OP_CHAR, 8'd65, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_WIDTH_WR, gql_pkg::NEWLINE_CODE, 8'd77, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_CHAR, gql_pkg::NEWLINE_CODE, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_WIDTH_WR, 8'd200, 8'd128, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_WIDTH_WR, 8'd127, 8'd127, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_CHAR, 8'd200, 8'd0, 0, 0, 1'b0, '0},
      '{gql_pkg::OP_CHAR, 8'd127, 8'd0, 0, 0, 1'b0, '0},
      '{OP_UNUSED, 8'd255, 8'd255, -1, -1, 1'b0, '0}
    };

    settings = '{
      '{8'd0, 9'd1, 17'd0, 17'd0, 12'd0},
      '{8'd255, 9'd256, 17'd65536, 17'd65536, 12'd4095},
      '{8'd0, 9'd0, 17'd65536, 17'd1, 12'd4095},
      '{8'd128, 9'd3, 17'd30000, 17'd20000, 12'd100},
      '0,
      '{gql_pkg::BASE_CHAR_RST, gql_pkg::ROW_PITCH_RST, gql_pkg::COL_STEP_RST,
        gql_pkg::ROW_STEP_RST, gql_pkg::LINE_HEIGHT_RST}
    };
    settings[4].base = 8'($urandom);
    settings[4].pitch = 9'($urandom_range(1, 256));
    settings[4].col_step = 17'($urandom_range(0, 65536));
    settings[4].row_step = 17'($urandom_range(0, 65536));
    settings[4].lh = 12'($urandom_range(0, 4095));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      drow = directed_tbl[i];
      it.op = drow.op;
      it.code = drow.code;
      it.gw = drow.gw;
      it.ox = drow.ox[15:0];
      it.oy = drow.oy[15:0];
      push_item(it, drow.typed, drow.q);
    end

    for (int s = 0; s < N_SETTINGS; s++) begin
      in_tvalid <= 1'b0;
      load_setting(settings[s]);
      it = random_item();
      it.op = gql_pkg::OP_START;
      if (s == N_SETTINGS - 1) begin
        // The output is held off for a long stretch while one string runs past the
        // character limit, so the block backs up and the vertex count wraps.
        hold_req = 1'b1;
        push_item(it, 1'b0, '0);
        for (int i = 0; i < gql_pkg::MAX_CHARS_DEF + 4; i++) begin
          it = random_item();
          it.op = gql_pkg::OP_CHAR;
          it.code = known_codes[$urandom_range(0, known_codes.size() - 1)];
          if (i >= gql_pkg::MAX_CHARS_DEF && i % 2 == 1) begin
            it.code = gql_pkg::NEWLINE_CODE;
          end else if (it.code == gql_pkg::NEWLINE_CODE) begin
            it.code = 8'd0;
          end
          push_item(it, 1'b0, '0);
        end
      end else begin
        push_item(it, 1'b0, '0);
        repeat (PHASE_ITEMS) push_item(random_item(), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);

    $display("Run covered %0d input beats, %0d vertices, %0d register writes, %0d dropped chars.",
             n_items, n_vertices, n_cfg, n_dropped);
    $display("Atlas settings ranged from all-minimum to all-maximum, zero pitch included.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
